[hdl/lbm_pkg.sv]
// Shared constants, the sequencer state type and small helper functions
// for the Lorentz boost matrix generator. No dependencies.
`default_nettype none

package lbm_pkg;

  // Moving-average window.
  localparam int WINDOW_LEN = 16;
  localparam int WIN_POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int WIN_CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W      = 32 + WIN_POS_W;

  // Digit-serial multiplier: 32 x 32, four bits of the multiplier per cycle.
  localparam int MUL_W     = 32;
  localparam int MUL_DIG   = 4;
  localparam int MUL_STEPS = MUL_W / MUL_DIG;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // Bit-serial restoring divider: 49-bit dividend, 32-bit divisor.
  localparam int DIV_NW    = 49;
  localparam int DIV_DW    = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NW);

  // Bit-serial square root: 64-bit radicand, 32-bit root.
  localparam int SQ_RW    = 64;
  localparam int SQ_QW    = 32;
  localparam int SQ_CNT_W = $clog2(SQ_QW);

  // Matrix storage: entry 0 is gamma, 1..3 are gamma*v_i, 4..9 the spatial
  // block in the pair order (0,0) (0,1) (0,2) (1,1) (1,2) (2,2).
  localparam int N_ENT  = 10;
  localparam int N_PAIR = 6;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd1;

  localparam logic [31:0] Q_ONE        = 32'h0001_0000;
  localparam logic [31:0] SCALE_RESET  = 32'h0001_0000;
  localparam logic [15:0] LIMIT_RESET  = 16'd58982;
  localparam logic [DIV_NW-1:0] G_NUM  = 49'h1_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_LEN, S_SPD, S_WIN, S_AVG, S_SCL, S_VV,
    S_ROOT, S_G, S_F, S_VM, S_VD, S_EM, S_DONE
  } state_e;

  function automatic logic [1:0] pair_a(input logic [2:0] n);
    logic [1:0] r;
    case (n)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] n);
    logic [1:0] r;
    case (n)
      3'd0:       r = 2'd0;
      3'd1, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  // Storage index of matrix element (row j, column k).
  function automatic logic [3:0] ent_sel(input logic [1:0] j, input logic [1:0] k);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [3:0] r;
    lo = (j < k) ? j : k;
    hi = (j < k) ? k : j;
    if (lo == 2'd0) begin
      r = {2'b00, hi};
    end else begin
      case ({lo, hi})
        4'b0101: r = 4'd4;
        4'b0110: r = 4'd5;
        4'b0111: r = 4'd6;
        4'b1010: r = 4'd7;
        4'b1011: r = 4'd8;
        default: r = 4'd9;
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] ident_ent(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0, 4'd4, 4'd7, 4'd9: r = Q_ONE;
      default:                r = 32'h0;
    endcase
    return r;
  endfunction

  // Sign-magnitude to saturated two's complement.
  function automatic logic [31:0] sat_q(input logic neg, input logic [48:0] mag);
    logic [31:0] r;
    if (!neg) begin
      r = (mag > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      r = (mag > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(32'h0 - mag[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/lbm_mul.sv]
// Digit-serial unsigned multiplier, one 4-bit digit of the multiplier per cycle.
// Depends on lbm_pkg.
`default_nettype none

module lbm_mul import lbm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [MUL_W-1:0]   a_i,
  input  wire logic [MUL_W-1:0]   b_i,
  output logic [2*MUL_W-1:0]      prod_o,
  output logic                    done_o
);

  logic [MUL_W-1:0]         a_q;
  logic [2*MUL_W-1:0]       prod_q;
  logic [MUL_CNT_W-1:0]     cnt_q;
  logic                     busy_q;
  logic                     done_q;
  logic [MUL_W+MUL_DIG-1:0] psum;

  // The multiplier sits in the low half of the product register and is
  // consumed from its low end while the partial sum shifts in from the top.
  assign psum = {{MUL_DIG{1'b0}}, prod_q[2*MUL_W-1:MUL_W]}
              + ({{MUL_DIG{1'b0}}, a_q} * {{MUL_W{1'b0}}, prod_q[MUL_DIG-1:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{MUL_W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {psum, prod_q[MUL_W-1:MUL_DIG]};
    end
  end

  assign prod_o = prod_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[hdl/lbm_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lbm_pkg.
`default_nettype none

module lbm_div import lbm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_NW-1:0] dividend_i,
  input  wire logic [DIV_DW-1:0] divisor_i,
  output logic [DIV_NW-1:0]      quot_o,
  output logic                   done_o
);

  logic [DIV_NW-1:0]    quo_q;
  logic [DIV_DW-1:0]    rem_q;
  logic [DIV_DW-1:0]    dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIV_DW:0]      trial;
  logic [DIV_DW:0]      diff;
  logic                 ge;

  // The dividend shifts out of the top of quo_q while quotient bits enter below.
  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NW-2:0], ge};
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[hdl/lbm_sqrt.sv]
// Bit-serial integer square root, one root bit (two radicand bits) per cycle.
// Depends on lbm_pkg.
`default_nettype none

module lbm_sqrt import lbm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SQ_RW-1:0] rad_i,
  output logic [SQ_QW-1:0]      root_o,
  output logic                  done_o
);

  logic [SQ_RW-1:0]    rad_q;
  logic [SQ_QW+1:0]    rem_q;
  logic [SQ_QW-1:0]    root_q;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [SQ_QW+3:0]    trial;
  logic [SQ_QW+3:0]    tst;
  logic [SQ_QW+3:0]    diff;
  logic                ge;

  assign trial = {rem_q, rad_q[SQ_RW-1:SQ_RW-2]};
  assign tst   = {2'b00, root_q, 2'b01};
  assign ge    = (trial >= tst);
  assign diff  = trial - tst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SQ_CNT_W'(SQ_QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQ_RW-3:0], 2'b00};
      rem_q  <= ge ? diff[SQ_QW+1:0] : trial[SQ_QW+1:0];
      root_q <= {root_q[SQ_QW-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[hdl/lorentz_boost_matrix_generator_top.sv]
// Top level of the Lorentz boost matrix generator: sequencer, speed window
// and output matrix register. Depends on lbm_pkg, lbm_mul, lbm_div, lbm_sqrt.
`default_nettype none

// Usage
// Each input beat carries one frame: a signed Q16.16 displacement and an
// unsigned Q16.16 frame time. It answers with four output beats, the columns
// of the 4x4 boost matrix in order 0..3, last_column_o marking the fourth.
// A still frame (zero displacement) gives the identity and leaves the speed
// history alone.
// A moving frame runs through one shared 4-bit-digit multiplier, one
// bit-serial divider and one bit-serial square root, with 23 products,
// seven quotients and two roots in all (fewer if its limited speed is zero).
// One frame is worked on at a time; in_stall_o is high while it is.
// Finished matrices go into an output register, so the next frame may be
// accepted while the columns of the previous one are still being taken.
// A stalled output beat holds its column. If the next matrix finishes before
// the old one has drained, the sequencer waits for the last column to leave.
// Reset clears the window history and sets speed_scale to 1.0 and
// speed_limit to about 0.9. Configuration is to be written through cfg_we_i
// only while the block is idle; the block itself does not enforce this.

module lorentz_boost_matrix_generator_top import lbm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [31:0]   disp_x_i,
  input  wire logic signed [31:0]   disp_y_i,
  input  wire logic signed [31:0]   disp_z_i,
  input  wire logic [31:0]          frame_time_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                column_index_o,
  output logic signed [31:0]        entry_row0_o,
  output logic signed [31:0]        entry_row1_o,
  output logic signed [31:0]        entry_row2_o,
  output logic signed [31:0]        entry_row3_o,
  output logic                      last_column_o
);

  state_e state_q, state_d;
  logic   launch_q, launch_d;
  logic [3:0] idx_q;
  logic   ident_q;

  // Per-frame working values.
  logic [31:0] mag_q [3];
  logic        neg_q [3];
  logic [31:0] ft_q;
  logic [63:0] sum_q;
  logic [31:0] len_q;
  logic [31:0] speed_q;
  logic [31:0] avg_q;
  logic [15:0] v_q;
  logic [31:0] dd_q;
  logic [31:0] s_q;
  logic [31:0] g_q;
  logic [31:0] f_q;
  logic [47:0] vm_q;
  logic [15:0] vel_q [3];
  logic [15:0] pp_q [N_PAIR];
  logic [31:0] ent_q [N_ENT];

  // Speed history.
  logic [31:0]          win_mem [WINDOW_LEN];
  logic [31:0]          old_q;
  logic [WIN_POS_W-1:0] wpos_q;
  logic [WIN_CNT_W-1:0] wcnt_q;
  logic [SUM_W-1:0]     wsum_q;

  logic [31:0] scale_q;
  logic [15:0] limit_q;

  // Output matrix register.
  logic [31:0] om_q [N_ENT];
  logic        ovalid_q;
  logic [1:0]  col_q;

  // Shared units.
  logic              mul_start, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [63:0]       mul_prod;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_d;
  logic [DIV_NW-1:0] div_quo;
  logic              sq_start, sq_done;
  logic [SQ_RW-1:0]  sq_rad;
  logic [SQ_QW-1:0]  sq_root;

  logic        accept;
  logic        in_zero;
  logic        out_fire;
  logic        out_free;
  logic [47:0] scaled;
  logic [15:0] v_new;
  logic [2:0]  em_n;
  logic [48:0] em_mag;
  logic        em_diag;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_zero  = (disp_x_i == 32'sd0) && (disp_y_i == 32'sd0) && (disp_z_i == 32'sd0);
  assign out_fire = ovalid_q && !out_stall_i;
  assign out_free = !ovalid_q || (out_fire && (col_q == 2'd3));

  assign scaled  = mul_prod[63:16];
  assign v_new   = (scaled < {32'h0, limit_q}) ? scaled[15:0] : limit_q;
  assign em_n    = (idx_q >= 4'd9) ? 3'(idx_q - 4'd9) : 3'(idx_q - 4'd3);
  assign em_mag  = {1'b0, mul_prod[63:16]};
  assign em_diag = (pair_a(em_n) == pair_b(em_n));

  lbm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  lbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .quot_o     (div_quo),
    .done_o     (div_done)
  );

  lbm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .root_o  (sq_root),
    .done_o  (sq_done)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = in_zero ? S_DONE : S_SQ;
      S_SQ:   if (mul_done && (idx_q == 4'd2)) state_d = S_LEN;
      S_LEN:  if (sq_done) state_d = S_SPD;
      S_SPD:  if (div_done) state_d = S_WIN;
      S_WIN:  state_d = S_AVG;
      S_AVG:  if (div_done) state_d = S_SCL;
      S_SCL:  if (mul_done) state_d = (v_new == 16'h0) ? S_DONE : S_VV;
      S_VV:   if (mul_done) state_d = S_ROOT;
      S_ROOT: if (sq_done) state_d = S_G;
      S_G:    if (div_done) state_d = S_F;
      S_F:    if (div_done) state_d = S_VM;
      S_VM:   if (mul_done) state_d = S_VD;
      S_VD:   if (div_done) state_d = (idx_q == 4'd2) ? S_EM : S_VM;
      S_EM:   if (mul_done && (idx_q == 4'd14)) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Unit launches and operand selection. Each arithmetic state starts its unit,
  // waits for the done pulse and, in S_SQ and S_EM, starts it again for the next index.
  always_comb begin
    mul_start = (state_q inside {S_SQ, S_SCL, S_VV, S_VM, S_EM}) && !launch_q;
    div_start = (state_q inside {S_SPD, S_AVG, S_G, S_F, S_VD}) && !launch_q;
    sq_start  = (state_q inside {S_LEN, S_ROOT}) && !launch_q;

    if (mul_done || div_done || sq_done) begin
      launch_d = 1'b0;
    end else begin
      launch_d = launch_q || mul_start || div_start || sq_start;
    end

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        mul_a = mag_q[idx_q[1:0]];
        mul_b = mag_q[idx_q[1:0]];
      end
      S_SCL: begin
        mul_a = avg_q;
        mul_b = scale_q;
      end
      S_VV: begin
        mul_a = {16'h0, v_q};
        mul_b = {16'h0, v_q};
      end
      S_VM: begin
        mul_a = {16'h0, v_q};
        mul_b = mag_q[idx_q[1:0]];
      end
      S_EM: begin
        if (idx_q < 4'd3) begin
          mul_a = g_q;
          mul_b = {16'h0, vel_q[idx_q[1:0]]};
        end else if (idx_q < 4'd9) begin
          mul_a = {16'h0, vel_q[pair_a(em_n)]};
          mul_b = {16'h0, vel_q[pair_b(em_n)]};
        end else begin
          mul_a = f_q;
          mul_b = {16'h0, pp_q[em_n]};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    div_n = '0;
    div_d = '0;
    case (state_q)
      S_SPD: begin
        div_n = {1'b0, len_q, 16'h0};
        div_d = ft_q;
      end
      S_AVG: begin
        div_n = DIV_NW'(wsum_q);
        div_d = DIV_DW'(wcnt_q);
      end
      S_G: begin
        div_n = G_NUM;
        div_d = s_q;
      end
      S_F: begin
        div_n = {1'b0, g_q - Q_ONE, 16'h0};
        div_d = {16'h0, v_q};
      end
      S_VD: begin
        div_n = {1'b0, vm_q};
        div_d = len_q;
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase

    sq_rad = (state_q == S_ROOT) ? {dd_q, 32'h0} : sum_q;
  end

  // Control state, history and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      idx_q    <= '0;
      ident_q  <= 1'b0;
      wpos_q   <= '0;
      wcnt_q   <= '0;
      wsum_q   <= '0;
      scale_q  <= SCALE_RESET;
      limit_q  <= LIMIT_RESET;
      ovalid_q <= 1'b0;
      col_q    <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;

      if (accept) begin
        idx_q   <= '0;
        ident_q <= in_zero;
      end else if (((state_q == S_SQ) && mul_done) || ((state_q == S_VD) && div_done)) begin
        idx_q <= (idx_q == 4'd2) ? 4'd0 : idx_q + 4'd1;
      end else if ((state_q == S_EM) && mul_done) begin
        idx_q <= idx_q + 4'd1;
      end

      if ((state_q == S_SCL) && mul_done && (v_new == 16'h0)) begin
        ident_q <= 1'b1;
      end

      if (state_q == S_WIN) begin
        if (wcnt_q == WIN_CNT_W'(WINDOW_LEN)) begin
          wsum_q <= wsum_q - SUM_W'(old_q) + SUM_W'(speed_q);
        end else begin
          wcnt_q <= wcnt_q + 1'b1;
          wsum_q <= wsum_q + SUM_W'(speed_q);
        end
        wpos_q <= (wpos_q == WIN_POS_W'(WINDOW_LEN - 1)) ? '0 : wpos_q + 1'b1;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SPEED_SCALE: scale_q <= cfg_data_i;
          CFG_SPEED_LIMIT: limit_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if ((state_q == S_DONE) && out_free) begin
        ovalid_q <= 1'b1;
        col_q    <= '0;
      end else if (out_fire) begin
        col_q <= col_q + 2'd1;
        if (col_q == 2'd3) ovalid_q <= 1'b0;
      end
    end
  end

  // Window memory: the oldest entry is read continuously at the write position,
  // which only moves in the update cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WIN) win_mem[wpos_q] <= speed_q;
    old_q <= win_mem[wpos_q];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q[0] <= disp_x_i[31] ? 32'(32'h0 - disp_x_i) : disp_x_i;
      mag_q[1] <= disp_y_i[31] ? 32'(32'h0 - disp_y_i) : disp_y_i;
      mag_q[2] <= disp_z_i[31] ? 32'(32'h0 - disp_z_i) : disp_z_i;
      neg_q[0] <= disp_x_i[31];
      neg_q[1] <= disp_y_i[31];
      neg_q[2] <= disp_z_i[31];
      ft_q     <= frame_time_i;
      sum_q    <= '0;
    end

    case (state_q)
      S_SQ:   if (mul_done) sum_q <= sum_q + mul_prod;
      S_LEN:  if (sq_done) len_q <= sq_root;
      S_SPD: begin
        if (div_done) begin
          speed_q <= (div_quo[48:32] != 17'h0) ? 32'hFFFF_FFFF : div_quo[31:0];
        end
      end
      S_AVG:  if (div_done) avg_q <= div_quo[31:0];
      S_SCL:  if (mul_done) v_q <= v_new;
      S_VV:   if (mul_done) dd_q <= 32'h0 - mul_prod[31:0];
      S_ROOT: if (sq_done) s_q <= sq_root;
      S_G:    if (div_done) g_q <= div_quo[31:0];
      S_F: begin
        if (div_done) begin
          f_q      <= div_quo[31:0];
          ent_q[0] <= g_q;
        end
      end
      S_VM:   if (mul_done) vm_q <= mul_prod[47:0];
      S_VD:   if (div_done) vel_q[idx_q[1:0]] <= div_quo[15:0];
      S_EM: begin
        if (mul_done) begin
          if (idx_q < 4'd3) begin
            ent_q[4'(idx_q + 4'd1)] <= sat_q(neg_q[idx_q[1:0]], em_mag);
          end else if (idx_q < 4'd9) begin
            pp_q[em_n] <= mul_prod[31:16];
          end else begin
            ent_q[4'(idx_q - 4'd5)] <= sat_q(
              (neg_q[pair_a(em_n)] ^ neg_q[pair_b(em_n)]) && !em_diag,
              em_mag + (em_diag ? 49'(Q_ONE) : 49'h0));
          end
        end
      end
      default: ;
    endcase

    if ((state_q == S_DONE) && out_free) begin
      for (int i = 0; i < N_ENT; i++) begin
        om_q[i] <= ident_q ? ident_ent(4'(i)) : ent_q[i];
      end
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ovalid_q;
  assign column_index_o = col_q;
  assign entry_row0_o   = om_q[ent_sel(2'd0, col_q)];
  assign entry_row1_o   = om_q[ent_sel(2'd1, col_q)];
  assign entry_row2_o   = om_q[ent_sel(2'd2, col_q)];
  assign entry_row3_o   = om_q[ent_sel(2'd3, col_q)];
  assign last_column_o  = (col_q == 2'd3);

`ifndef SYNTHESIS
  a_wcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= WIN_CNT_W'(WINDOW_LEN))
    else $error("window count beyond window length");

  a_wpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= WIN_POS_W'(WINDOW_LEN - 1))
    else $error("window write position out of range");

  a_v_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VV) |-> (v_q != 16'h0))
    else $error("boost computed for zero speed");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (col_q == 2'd3) && (state_q != S_DONE)) |=> !out_valid_o)
    else $error("output still valid after last column");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for lorentz_boost_matrix_generator_top.
// Depends on lbm_pkg and the block's RTL; it predicts every matrix column in place.
`default_nettype none

module tb import lbm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes past the defined list; the block must ignore writes there.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // One expected output beat: a single matrix column.
  typedef struct {
    logic [1:0]  col;
    logic [31:0] row [4];
    logic        last;
  } column_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SPEED_SCALE;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] disp_x = '0, disp_y = '0, disp_z = '0;
  logic [31:0] frame_time = 32'h0001_0000;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] column_index;
  logic signed [31:0] entry_row0, entry_row1, entry_row2, entry_row3;
  logic last_column;

  always #1 clk = ~clk;

  lorentz_boost_matrix_generator_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .disp_x_i(disp_x), .disp_y_i(disp_y), .disp_z_i(disp_z),
    .frame_time_i(frame_time),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .column_index_o(column_index),
    .entry_row0_o(entry_row0), .entry_row1_o(entry_row1),
    .entry_row2_o(entry_row2), .entry_row3_o(entry_row3),
    .last_column_o(last_column)
  );

  // Predictor copy of the configuration and the speed history.
  logic [31:0] scale_q = SCALE_RESET;
  logic [15:0] limit_q = LIMIT_RESET;
  logic [31:0] speed_hist [WINDOW_LEN];
  int unsigned hist_count = 0;
  int unsigned hist_pos = 0;
  logic [63:0] hist_sum = '0;

  column_t pending_columns [$];
  int error_count = 0;
  int frames_sent = 0;
  int moving_frames = 0;
  int columns_seen = 0;

  // Output pacing: the receiver stall style is changed by each test.
  int stall_style = 0;
  int stall_run = 0;
  // Input pacing: bursts of back-to-back frames separated by random gaps.
  int burst_left = 0;
  int max_gap = 12;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] magnitude(longint signed a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  // Signed Q16.16 product truncated toward zero.
  function automatic longint signed q_product(longint signed a, longint signed b);
    logic [63:0] m;
    m = (magnitude(a) * magnitude(b)) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp32(longint signed e);
    if (e > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (e < -64'sd2147483648) return 32'h8000_0000;
    return e[31:0];
  endfunction

  // Updates the speed history and queues the four columns of the boost matrix.
  task automatic predict_boost(logic signed [31:0] dx, logic signed [31:0] dy,
                               logic signed [31:0] dz, logic [31:0] ft);
    longint signed d [3];
    longint signed vel [3];
    longint signed g, f, e;
    logic [63:0] len, speed, avg, scaled, v, s, m;
    column_t c;
    d[0] = dx; d[1] = dy; d[2] = dz;
    vel[0] = 0; vel[1] = 0; vel[2] = 0;
    g = 65536;
    f = 0;
    if (dx != 0 || dy != 0 || dz != 0) begin
      moving_frames++;
      len = int_sqrt(magnitude(d[0]) * magnitude(d[0]) + magnitude(d[1]) * magnitude(d[1])
                     + magnitude(d[2]) * magnitude(d[2]));
      if (ft == 0) begin
        speed = 64'hFFFF_FFFF;
      end else begin
        speed = (len << 16) / ft;
        if (speed > 64'hFFFF_FFFF) speed = 64'hFFFF_FFFF;
      end
      // Once the window is full the oldest speed drops out of the sum.
      if (hist_count >= WINDOW_LEN) hist_sum = hist_sum - speed_hist[hist_pos];
      else hist_count++;
      speed_hist[hist_pos] = speed[31:0];
      hist_sum = hist_sum + speed;
      hist_pos = (hist_pos + 1) % WINDOW_LEN;
      avg = hist_sum / hist_count;
      scaled = (avg * scale_q) >> 16;
      v = (scaled < limit_q) ? scaled : 64'(limit_q);
      if (v > 0) begin
        s = int_sqrt(((64'h1 << 32) - v * v) << 32);
        g = longint'((64'h1 << 48) / s);
        f = longint'(((64'(g) - 65536) << 16) / v);
        for (int i = 0; i < 3; i++) begin
          m = (v * magnitude(d[i])) / len;
          vel[i] = (d[i] < 0) ? -longint'(m) : longint'(m);
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      c.col = k[1:0];
      c.last = (k == 3);
      for (int j = 0; j < 4; j++) begin
        if (j == 0 && k == 0) e = g;
        else if (j == 0) e = q_product(g, vel[k-1]);
        else if (k == 0) e = q_product(g, vel[j-1]);
        else e = q_product(f, q_product(vel[j-1], vel[k-1])) + ((j == k) ? 65536 : 0);
        c.row[j] = clamp32(e);
      end
      pending_columns = {pending_columns, c};
    end
  endtask

  // Drives one frame and holds it until the block takes it. Valid stays high
  // on return so that a following frame may go out in the next cycle.
  task automatic send_frame(logic signed [31:0] dx, logic signed [31:0] dy,
                            logic signed [31:0] dz, logic [31:0] ft);
    in_valid <= 1'b1;
    disp_x <= dx;
    disp_y <= dy;
    disp_z <= dz;
    frame_time <= ft;
    do @(posedge clk); while (in_stall);
    predict_boost(dx, dy, dz, ft);
    frames_sent++;
  endtask

  // Between frames: either keep streaming or drop valid for a random gap.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      if (max_gap > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk);
      end
    end
  endtask

  // Waits until every queued column has come back, leaving the block idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write; the enable is dropped again before the next write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SPEED_SCALE) scale_q = value;
    else if (idx == CFG_SPEED_LIMIT) limit_q = value[15:0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom() >> $urandom_range(8, 31);
      2: return -($urandom() >> $urandom_range(8, 31));
      default: return $urandom() >> $urandom_range(16, 24);
    endcase
  endfunction

  function automatic logic [31:0] random_time();
    case ($urandom_range(0, 2))
      0: return $urandom() | 32'h1;
      1: return ($urandom() >> $urandom_range(0, 31)) | 32'h1;
      default: return $urandom_range(32'h0000_0400, 32'h0004_0000);
    endcase
  endfunction

  // Receiver stall driver. Style 0 never stalls, style 1 stalls on about half
  // the cycles, style 2 holds long stretches of stall and go.
  always @(posedge clk) begin
    case (stall_style)
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 40);
          out_stall <= ~out_stall;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
      default: out_stall <= 1'b0;
    endcase
  end

  // Compares each accepted column beat with the oldest prediction.
  always @(posedge clk) begin
    column_t c;
    logic [31:0] got [4];
    if (rst_n && out_valid && !out_stall) begin
      columns_seen++;
      if (pending_columns.size() == 0) begin
        $error("column beat %0d arrived with nothing expected", column_index);
        error_count++;
      end else begin
        c = pending_columns[0];
        pending_columns.delete(0);
        got[0] = entry_row0; got[1] = entry_row1;
        got[2] = entry_row2; got[3] = entry_row3;
        if (column_index !== c.col) begin
          $error("column_index: expected %0d, got %0d", c.col, column_index);
          error_count++;
        end
        for (int j = 0; j < 4; j++) begin
          if (got[j] !== c.row[j]) begin
            $error("entry_row%0d (column %0d): expected %h, got %h", j, c.col,
                   c.row[j], got[j]);
            error_count++;
          end
        end
        if (last_column !== c.last) begin
          $error("last_column: expected %b, got %b", c.last, last_column);
          error_count++;
        end
      end
    end
  end

  // Still frames give the identity and must leave the history untouched; one moving frame is sent among them.
  task automatic test_still_frames();
    stall_style = 0;
    send_frame(0, 0, 0, 32'h0001_0000);
    send_frame(0, 0, 0, 32'hFFFF_FFFF);
    send_frame(32'sh0001_0000, 0, 0, 32'h0001_0000);
    send_frame(0, 0, 0, 32'h1);
    drain();
  endtask

  // Field extremes, zero frame time, and one axis at a time.
  task automatic test_extremes();
    stall_style = 1;
    send_frame(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h1);
    send_frame(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_frame(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'h0001_0000);
    send_frame(1, 0, 0, 32'hFFFF_FFFF);
    send_frame(0, -1, 0, 32'h1);
    send_frame(0, 0, 32'sh0000_8000, 32'h0);
    send_frame(-32'sh0003_0000, 32'sh0004_0000, 0, 32'h0000_0444);
    send_frame(32'sh0000_1000, -32'sh0000_2000, 32'sh0000_3000, 32'h0000_1111);
    drain();
  endtask

  // Twenty frames push the history past one full window so old speeds leave the sum.
  task automatic test_window_wrap();
    stall_style = 2;
    for (int i = 0; i < 20; i++) begin
      send_frame(32'sh0000_0100 * (i + 1), -32'sh0000_0080, 32'sh0000_0040 * i,
                 32'h0001_0000 + 32'h0000_1000 * i);
      pace_sender();
    end
    drain();
  endtask

  // Random frames: mostly moving, some still, under one register setting.
  task automatic test_random_phase(int count, logic [31:0] scale, logic [31:0] limit);
    logic signed [31:0] x, y, z;
    write_reg(CFG_SPEED_SCALE, scale);
    write_reg(CFG_SPEED_LIMIT, limit);
    stall_style = $urandom_range(0, 2);
    max_gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        x = 0; y = 0; z = 0;
      end else begin
        x = random_word();
        y = ($urandom_range(0, 4) == 0) ? 32'sh0 : random_word();
        z = ($urandom_range(0, 4) == 0) ? 32'sh0 : random_word();
      end
      send_frame(x, y, z, random_time());
      pace_sender();
    end
    drain();
  endtask

  // Writes to the unused indexes must leave both registers as they are.
  task automatic test_spare_indexes();
    write_reg(CFG_SPARE_A, 32'h0000_0001);
    write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
    send_frame(32'sh0002_0000, 32'sh0001_0000, -32'sh0001_0000, 32'h0001_0000);
    send_frame(-32'sh0000_4000, 0, 32'sh0000_4000, 32'h0000_8000);
    drain();
  endtask

  initial begin
    for (int i = 0; i < WINDOW_LEN; i++) speed_hist[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_still_frames();
    test_extremes();
    test_window_wrap();
    test_spare_indexes();
    test_random_phase(60, 32'h0000_0000, 32'h0000_FFFF);
    test_random_phase(60, 32'hFFFF_FFFF, 32'h0000_FFFF);
    test_random_phase(60, 32'h0001_0000, 32'h0000_0000);
    test_random_phase(60, $urandom(), $urandom_range(0, 65535));
    test_random_phase(60, $urandom_range(32'h0000_0100, 32'h0004_0000), 32'h0000_0001);
    test_random_phase(60, SCALE_RESET, LIMIT_RESET);

    $display("tb: %0d frames (%0d moving) across scale and limit extremes, %0d column beats",
             frames_sent, moving_frames, columns_seen);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
